FILE: design/mkra_pkg.sv
package mkra_pkg;

  localparam int MaxRecords = 64;
  localparam int StoreMax   = 64;
  localparam int IndexW     = 6;
  localparam int IdW        = 32;
  localparam int ExpW       = 11;
  localparam int MantW      = 31;
  localparam int KeyW       = 1 + 3 * IdW + ExpW + MantW + IndexW;
  localparam int InDataW    = 144;
  localparam int OutDataW   = 8;
  localparam int PaddrW     = 3;
  localparam int ApbDataW   = 32;

  localparam logic [1:0] ModeTaxon   = 2'd0;
  localparam logic [1:0] ModeSubject = 2'd1;
  localparam logic [1:0] ModeEvalue  = 2'd2;

  localparam logic RegSortMode = 1'b0;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic                    valid;
    logic [IdW-1:0]          query;
    logic [IdW-1:0]          subject;
    logic [IdW-1:0]          taxon;
    logic signed [ExpW-1:0]  exponent;
    logic [MantW-1:0]        mantissa;
    logic [IndexW-1:0]       index;
  } record_t;

  typedef struct packed {
    logic load;
    logic take_left;
    logic take_right;
  } cell_ctrl_t;

  // Builds an unsigned key so that one magnitude compare gives the record order.
  // Empty cells carry a set top bit and sort behind every stored record.
  function automatic logic [KeyW-1:0] sort_key(record_t r, logic [1:0] mode);
    logic [IdW-1:0]  second;
    logic [ExpW-1:0] expo;
    logic [MantW-1:0] mant;
    second = '0;
    expo   = '0;
    mant   = '0;
    case (mode)
      ModeSubject: begin
      end
      ModeEvalue: begin
        expo = {~r.exponent[ExpW-1], r.exponent[ExpW-2:0]};
        mant = r.mantissa;
      end
      default: begin
        second = r.taxon;
        expo   = {~r.exponent[ExpW-1], r.exponent[ExpW-2:0]};
        mant   = r.mantissa;
      end
    endcase
    return {~r.valid, r.query, second, expo, mant, r.subject, r.index};
  endfunction

endpackage

FILE: design/multi_key_record_argsort.sv
// Loading takes one word per cycle; the first STORE records (STORE = min(MAX_RECORDS, 64))
// are each written straight into their cell, and later words of the set are dropped.
// After the word marked tlast the chain runs an odd-even exchange sort, its neighbor
// compares alternating between even and odd cell pairs. The sorted indices then leave
// one per cycle from the head of the chain while m_axis_tready is high.
// Reset is asynchronous, active low; it empties the store and sets sort_mode to 0.
module multi_key_record_argsort #(
  parameter int MAX_RECORDS = mkra_pkg::MaxRecords
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // query, subject, taxon, exponent, mantissa
  input  logic [mkra_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // sorted position's arrival index
  output logic [mkra_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                           m_axis_tlast,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mkra_pkg::PaddrW-1:0]    paddr,
  input  logic [mkra_pkg::ApbDataW-1:0]  pwdata,
  output logic [mkra_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);

  localparam int Store = (MAX_RECORDS < mkra_pkg::StoreMax) ? MAX_RECORDS
                                                             : mkra_pkg::StoreMax;
  localparam int IdxW  = $clog2(Store);
  localparam int CntW  = $clog2(Store + 1);

  mkra_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  remain_q, remain_d;
  logic [IdxW-1:0]  pass_q, pass_d;
  logic [1:0]       mode_q;

  mkra_pkg::record_t            rec   [Store];
  logic [mkra_pkg::KeyW-1:0]    key   [Store];
  logic [Store-1:0]             swap;
  mkra_pkg::record_t            new_rec;

  logic in_fire, out_fire, store_en, emit_shift;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == mkra_pkg::RegSortMode)
                  ? {{(mkra_pkg::ApbDataW-2){1'b0}}, mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= mkra_pkg::ModeTaxon;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == mkra_pkg::RegSortMode) begin
      mode_q <= pwdata[1:0];
    end
  end

  assign s_axis_tready = (state_q == mkra_pkg::ST_LOAD);
  assign m_axis_tvalid = (state_q == mkra_pkg::ST_EMIT);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = m_axis_tvalid && m_axis_tready;
  assign store_en      = in_fire && (count_q < CntW'(Store));
  assign emit_shift    = out_fire;

  assign m_axis_tdata  = {{(mkra_pkg::OutDataW-mkra_pkg::IndexW){1'b0}}, rec[0].index};
  assign m_axis_tlast  = (remain_q == CntW'(1));

  always_comb begin
    new_rec.valid    = 1'b1;
    new_rec.query    = s_axis_tdata[31:0];
    new_rec.subject  = s_axis_tdata[63:32];
    new_rec.taxon    = s_axis_tdata[95:64];
    new_rec.exponent = s_axis_tdata[106:96];
    new_rec.mantissa = s_axis_tdata[137:107];
    new_rec.index    = mkra_pkg::IndexW'(count_q[IdxW-1:0]);
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    remain_d = remain_q;
    pass_d   = pass_q;
    case (state_q)
      mkra_pkg::ST_LOAD: begin
        if (store_en) begin
          count_d = count_q + CntW'(1);
        end
        if (in_fire && s_axis_tlast) begin
          state_d  = mkra_pkg::ST_SORT;
          remain_d = store_en ? count_q + CntW'(1) : count_q;
          pass_d   = '0;
        end
      end
      mkra_pkg::ST_SORT: begin
        pass_d = pass_q + IdxW'(1);
        if (pass_q == IdxW'(Store - 1)) begin
          state_d = mkra_pkg::ST_EMIT;
        end
      end
      mkra_pkg::ST_EMIT: begin
        if (out_fire) begin
          remain_d = remain_q - CntW'(1);
          if (remain_q == CntW'(1)) begin
            state_d = mkra_pkg::ST_LOAD;
            count_d = '0;
          end
        end
      end
      default: begin
        state_d = mkra_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mkra_pkg::ST_LOAD;
      count_q  <= '0;
      remain_q <= '0;
      pass_q   <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      remain_q <= remain_d;
      pass_q   <= pass_d;
    end
  end

  for (genvar i = 0; i < Store; i++) begin : g_chain
    localparam logic Parity = 1'(i % 2);
    mkra_pkg::cell_ctrl_t ctrl;
    mkra_pkg::record_t    left_rec, right_rec;

    if (i < Store - 1) begin : g_pair
      assign swap[i] = (state_q == mkra_pkg::ST_SORT) && (pass_q[0] == Parity)
                       && (key[i+1] < key[i]);
      assign right_rec = rec[i+1];
    end else begin : g_tail
      assign swap[i]   = 1'b0;
      assign right_rec = '0;
    end

    if (i > 0) begin : g_left
      assign left_rec       = rec[i-1];
      assign ctrl.take_left = swap[i-1];
    end else begin : g_head
      assign left_rec       = '0;
      assign ctrl.take_left = 1'b0;
    end

    assign ctrl.load       = store_en && (count_q == CntW'(i));
    assign ctrl.take_right = swap[i] || emit_shift;

    mkra_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .mode_i  (mode_q),
      .new_i   (new_rec),
      .left_i  (left_rec),
      .right_i (right_rec),
      .rec_o   (rec[i]),
      .key_o   (key[i])
    );
  end

`ifndef SYNTH
  a_head_valid_on_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> rec[0].valid)
    else $error("Sorted word offered from an empty head cell.");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Store))
    else $error("Load count exceeds the chain length.");

  a_remain_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> remain_q != '0 && remain_q <= count_q)
    else $error("Emit count out of range.");

  a_sort_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mkra_pkg::ST_SORT && pass_q == IdxW'(Store - 1)) |=> m_axis_tvalid)
    else $error("Sort did not hand over to emission.");

  a_no_double_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("Loading and emitting at the same time.");
`endif

endmodule

FILE: design/mkra_cell.sv
module mkra_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mkra_pkg::cell_ctrl_t          ctrl_i,
  input  logic [1:0]                    mode_i,
  input  mkra_pkg::record_t             new_i,
  input  mkra_pkg::record_t             left_i,
  input  mkra_pkg::record_t             right_i,
  output mkra_pkg::record_t             rec_o,
  output logic [mkra_pkg::KeyW-1:0]     key_o
);

  mkra_pkg::record_t rec_q, rec_d;

  always_comb begin
    rec_d = rec_q;
    if (ctrl_i.load) begin
      rec_d = new_i;
    end else if (ctrl_i.take_right) begin
      rec_d = right_i;
    end else if (ctrl_i.take_left) begin
      rec_d = left_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else begin
      rec_q <= rec_d;
    end
  end

  assign rec_o = rec_q;
  assign key_o = mkra_pkg::sort_key(rec_q, mode_i);

endmodule

FILE: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StoreDepth = (mkra_pkg::MaxRecords < mkra_pkg::StoreMax)
                              ? mkra_pkg::MaxRecords : mkra_pkg::StoreMax;
  localparam int CycleLimit = 200000;
  localparam int SettleCycles = 8;
  localparam int DrainCycles = 2 * StoreDepth + 16;
  localparam int HoldCycles = 300;
  localparam logic [1:0] ModeUndefined = 2'd3;
  localparam logic [mkra_pkg::PaddrW-1:0] ModeRegAddr = {mkra_pkg::RegSortMode, 2'b00};
  localparam logic [mkra_pkg::PaddrW-1:0] UnusedRegAddr = 3'd4;

  typedef struct {
    logic [mkra_pkg::IdW-1:0] query;
    logic [mkra_pkg::IdW-1:0] subject;
    logic [mkra_pkg::IdW-1:0] taxon;
    logic signed [mkra_pkg::ExpW-1:0] exponent;
    logic [mkra_pkg::MantW-1:0] mantissa;
    logic [mkra_pkg::IndexW-1:0] slot;
  } hit_t;

  typedef struct {
    logic [mkra_pkg::IndexW-1:0] index;
    logic last;
  } rank_t;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  // query, subject, taxon, exponent, mantissa
  logic [mkra_pkg::InDataW-1:0] s_axis_tdata;
  logic s_axis_tlast;
  logic m_axis_tvalid;
  logic m_axis_tready;
  // sorted position's arrival index
  logic [mkra_pkg::OutDataW-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic psel;
  logic penable;
  logic pwrite;
  logic [mkra_pkg::PaddrW-1:0] paddr;
  logic [mkra_pkg::ApbDataW-1:0] pwdata;
  logic [mkra_pkg::ApbDataW-1:0] prdata;
  logic pready;

  hit_t held_hits[$];
  rank_t expected_ranks[$];
  logic [1:0] mode_shadow = mkra_pkg::ModeTaxon;
  bit idle_enable = 1'b1;
  int unsigned sink_hold_len = 0;
  int unsigned mismatch_count = 0;

  multi_key_record_argsort #(
    .MAX_RECORDS(mkra_pkg::MaxRecords)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("%0t: run did not finish within %0d cycles", $time, CycleLimit);
    $display("== FAIL ==");
    $finish;
  end

  function automatic bit sorts_ahead(input hit_t a, input hit_t b);
    if (a.query != b.query) return a.query < b.query;
    if (mode_shadow != mkra_pkg::ModeSubject) begin
      if (mode_shadow != mkra_pkg::ModeEvalue && a.taxon != b.taxon) begin
        return a.taxon < b.taxon;
      end
      if (a.exponent != b.exponent) return $signed(a.exponent) < $signed(b.exponent);
      if (a.mantissa != b.mantissa) return a.mantissa < b.mantissa;
    end
    if (a.subject != b.subject) return a.subject < b.subject;
    return a.slot < b.slot;
  endfunction

  // Stores an accepted record while fewer than StoreDepth are held and, on the final one, ranks the whole set.
  function automatic void record_hit(input hit_t h, input logic last);
    hit_t stored;
    int ranked[$];
    int pos;
    rank_t entry;
    if (held_hits.size() < StoreDepth) begin
      stored = h;
      stored.slot = mkra_pkg::IndexW'(held_hits.size());
      held_hits.push_back(stored);
    end
    if (last) begin
      foreach (held_hits[i]) begin
        pos = ranked.size();
        while (pos > 0 && sorts_ahead(held_hits[i], held_hits[ranked[pos-1]])) pos--;
        ranked.insert(pos, i);
      end
      foreach (ranked[k]) begin
        entry.index = held_hits[ranked[k]].slot;
        entry.last = (k == ranked.size() - 1);
        expected_ranks.push_back(entry);
      end
      held_hits.delete();
    end
  endfunction

  function automatic hit_t make_hit(input logic [mkra_pkg::IdW-1:0] query,
                                    input logic [mkra_pkg::IdW-1:0] subject,
                                    input logic [mkra_pkg::IdW-1:0] taxon,
                                    input logic signed [mkra_pkg::ExpW-1:0] exponent,
                                    input logic [mkra_pkg::MantW-1:0] mantissa);
    hit_t h;
    h.query = query;
    h.subject = subject;
    h.taxon = taxon;
    h.exponent = exponent;
    h.mantissa = mantissa;
    h.slot = '0;
    return h;
  endfunction

  // Each field comes from a tiny pool half of the time so that keys tie often.
  function automatic hit_t random_hit();
    hit_t h;
    h.query = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 2);
    h.subject = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 2);
    h.taxon = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 2);
    if ($urandom_range(0, 1)) h.exponent = mkra_pkg::ExpW'($urandom_range(0, 2047));
    else h.exponent = mkra_pkg::ExpW'(int'($urandom_range(0, 2)) - 1);
    h.mantissa = $urandom_range(0, 1) ? mkra_pkg::MantW'($urandom)
                 : mkra_pkg::MantW'(32'h3F80_0000 + $urandom_range(0, 1));
    h.slot = '0;
    return h;
  endfunction

  task automatic send_hit(input hit_t h, input logic last);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    s_axis_tdata <= {6'b0, h.mantissa, h.exponent, h.taxon, h.subject, h.query};
    s_axis_tlast <= last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    record_hit(h, last);
    @(negedge clk_i);
  endtask

  task automatic send_set(input hit_t hits[$]);
    foreach (hits[i]) send_hit(hits[i], i == hits.size() - 1);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_ranks.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [mkra_pkg::PaddrW-1:0] addr,
                           input logic [mkra_pkg::ApbDataW-1:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ModeRegAddr) mode_shadow = data[1:0];
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_mode_reg();
    psel <= 1'b1;
    pwrite <= 1'b0;
    paddr <= ModeRegAddr;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== mkra_pkg::ApbDataW'(mode_shadow)) begin
      $display("%0t: sort_mode read expected %0h actual %0h", $time, mode_shadow, prdata);
      mismatch_count++;
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_mode(input logic [1:0] mode);
    apb_write(ModeRegAddr, mkra_pkg::ApbDataW'(mode));
    check_mode_reg();
  endtask

  task automatic test_field_extremes();
    hit_t hits[$];
    check_mode_reg();
    hits.push_back(make_hit(32'h0, 32'h0, 32'h0, -11'sd1024, 31'h0));
    hits.push_back(make_hit('1, '1, '1, 11'sd1023, 31'h7FFF_FFFF));
    hits.push_back(make_hit(32'd5, 32'd9, 32'd7, -11'sd1, 31'h3F80_0000));
    hits.push_back(make_hit(32'd5, 32'd9, 32'd7, 11'sd0, 31'h3F80_0000));
    hits.push_back(make_hit(32'd5, 32'd1, 32'd7, -11'sd1, 31'h3F80_0001));
    hits.push_back(make_hit(32'd5, 32'd9, 32'd7, -11'sd1, 31'h3F80_0000));
    hits.push_back(make_hit(32'd5, '1, 32'd6, 11'sd1023, 31'h7FFF_FFFF));
    hits.push_back(make_hit(32'h0, '1, '1, 11'sd1023, 31'h7FFF_FFFF));
    send_set(hits);
    wait_idle();
  endtask

  task automatic test_single_record();
    hit_t hits[$];
    hits.push_back(random_hit());
    send_set(hits);
    wait_idle();
  endtask

  task automatic test_unused_register();
    apb_write(UnusedRegAddr, mkra_pkg::ApbDataW'(mkra_pkg::ModeSubject));
    check_mode_reg();
  endtask

  task automatic test_each_mode();
    logic [1:0] modes[4] = '{mkra_pkg::ModeTaxon, mkra_pkg::ModeSubject,
                             mkra_pkg::ModeEvalue, ModeUndefined};
    hit_t hits[$];
    foreach (modes[m]) begin
      set_mode(modes[m]);
      hits.delete();
      repeat (3) hits.push_back(random_hit());
      send_set(hits);
      wait_idle();
    end
  endtask

  task automatic test_store_full();
    hit_t hits[$];
    set_mode(mkra_pkg::ModeEvalue);
    repeat (StoreDepth + 2) hits.push_back(random_hit());
    send_set(hits);
    wait_idle();
  endtask

  task automatic test_random_sets(input int unsigned target);
    int unsigned sent;
    int unsigned n;
    hit_t hits[$];
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(0, 2) == 0) begin
        wait_idle();
        set_mode(2'($urandom_range(0, 3)));
        if ($urandom_range(0, 3) == 0) apb_write(UnusedRegAddr, $urandom);
      end
      n = $urandom_range(1, 6);
      hits.delete();
      repeat (n) hits.push_back(random_hit());
      send_set(hits);
      sent += n;
    end
    wait_idle();
  endtask

  task automatic test_output_hold();
    hit_t first_set[$];
    hit_t second_set[$];
    repeat (6) first_set.push_back(random_hit());
    repeat (4) second_set.push_back(random_hit());
    sink_hold_len = HoldCycles;
    send_set(first_set);
    send_set(second_set);
    wait_idle();
  endtask

  task automatic test_no_idle();
    hit_t hits[$];
    idle_enable = 1'b0;
    set_mode(2'($urandom_range(0, 3)));
    repeat (3) begin
      hits.delete();
      repeat ($urandom_range(1, 4)) hits.push_back(random_hit());
      send_set(hits);
    end
    wait_idle();
  endtask

  initial begin
    int unsigned stall_left;
    stall_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold_len != 0) begin
        stall_left = sink_hold_len;
        sink_hold_len = 0;
      end else if (stall_left == 0 && idle_enable && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      m_axis_tready <= (stall_left == 0);
      if (stall_left != 0) stall_left--;
    end
  end

  always @(posedge clk_i) begin
    rank_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_ranks.size() == 0) begin
        $display("%0t: unexpected word expected none actual index %0d last %0b", $time,
                 m_axis_tdata[mkra_pkg::IndexW-1:0], m_axis_tlast);
        mismatch_count++;
      end else begin
        want = expected_ranks.pop_front();
        if (m_axis_tdata[mkra_pkg::IndexW-1:0] !== want.index) begin
          $display("%0t: index expected %0d actual %0d", $time, want.index,
                   m_axis_tdata[mkra_pkg::IndexW-1:0]);
          mismatch_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: last_index expected %0b actual %0b", $time, want.last, m_axis_tlast);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_field_extremes();
    test_single_record();
    test_unused_register();
    test_each_mode();
    test_store_full();
    test_random_sets(8);
    test_output_hold();
    test_no_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
